// ===== rtl/slbs_pkg.sv =====
// ----------------------------------------------------------------------------
// slbs_pkg
// Shared types and constants for the status LED blink sequencer.
// ----------------------------------------------------------------------------
package slbs_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [15:0] ERR_HALF_RST = 16'd500;
  localparam logic [15:0] ID_HALF_RST  = 16'd300;

  // register index, taken from paddr[2]
  localparam logic REG_ERR_HALF = 1'b0;
  localparam logic REG_ID_HALF  = 1'b1;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_ERROR    = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_IDENTIFY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OFF   = 3'b001,
    ST_ERROR = 3'b010,
    ST_IDENT = 3'b100
  } led_fsm_t;

  localparam logic [1:0] LED_MODE_OFF   = 2'd0;
  localparam logic [1:0] LED_MODE_ERROR = 2'd1;
  localparam logic [1:0] LED_MODE_IDENT = 2'd2;

  typedef struct packed {
    logic       led_lit;
    logic [1:0] led_mode;
    logic       identify_finished;
  } result_t;

  function automatic logic [1:0] led_mode_code(input led_fsm_t st);
    logic [1:0] code;
    code = LED_MODE_OFF;
    case (st)
      ST_OFF:   code = LED_MODE_OFF;
      ST_ERROR: code = LED_MODE_ERROR;
      ST_IDENT: code = LED_MODE_IDENT;
      default:  code = LED_MODE_OFF;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/slbs_if.sv =====
// ----------------------------------------------------------------------------
// slbs_if
// Valid/ready channels for request beats and LED status beats.
// ----------------------------------------------------------------------------
interface slbs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] now_ms;
  logic [7:0]  blink_count;

  modport source (output valid, output mode, output now_ms, output blink_count,
                  input ready);
  modport sink   (input valid, input mode, input now_ms, input blink_count,
                  output ready);
endinterface

interface slbs_out_if;
  logic       valid;
  logic       ready;
  logic       led_lit;
  logic [1:0] led_mode;
  logic       identify_finished;

  modport source (output valid, output led_lit, output led_mode,
                  output identify_finished, input ready);
  modport sink   (input valid, input led_lit, input led_mode,
                  input identify_finished, output ready);
endinterface

// ===== rtl/slbs_cfg.sv =====
// ----------------------------------------------------------------------------
// slbs_cfg
// APB-style register block holding the error and identify half-periods.
// ----------------------------------------------------------------------------
module slbs_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [slbs_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [slbs_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [slbs_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output logic [15:0]                  err_half,
  output logic [15:0]                  id_half
);

  logic [15:0] err_half_r, err_half_nxt;
  logic [15:0] id_half_r, id_half_nxt;
  logic        wr_en;
  logic        reg_idx;

  assign wr_en   = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx = cfg_paddr[2];

  always_comb begin
    err_half_nxt = err_half_r;
    id_half_nxt  = id_half_r;
    if (wr_en) begin
      if (reg_idx == slbs_pkg::REG_ERR_HALF) begin
        err_half_nxt = cfg_pwdata[15:0];
      end else begin
        id_half_nxt = cfg_pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_half_r <= slbs_pkg::ERR_HALF_RST;
      id_half_r  <= slbs_pkg::ID_HALF_RST;
    end else begin
      err_half_r <= err_half_nxt;
      id_half_r  <= id_half_nxt;
    end
  end

  always_comb begin
    if (reg_idx == slbs_pkg::REG_ERR_HALF) begin
      cfg_prdata = {16'd0, err_half_r};
    end else begin
      cfg_prdata = {16'd0, id_half_r};
    end
  end

  assign cfg_pready = 1'b1;
  assign err_half   = err_half_r;
  assign id_half    = id_half_r;

endmodule

// ===== rtl/slbs_core.sv =====
// ----------------------------------------------------------------------------
// slbs_core
// LED mode state and next-state logic; advances one request beat per fire.
// ----------------------------------------------------------------------------
module slbs_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  logic [1:0]              mode,
  input  logic [31:0]             now_ms,
  input  logic [7:0]              blink_count,
  input  logic [15:0]             err_half,
  input  logic [15:0]             id_half,
  output slbs_pkg::result_t       result
);

  slbs_pkg::led_fsm_t st_r, st_nxt;
  logic        saved_err_r, saved_err_nxt;
  logic [31:0] last_r, last_nxt;
  logic        lit_r, lit_nxt;
  logic [7:0]  wanted_r, wanted_nxt;
  logic [7:0]  done_r, done_nxt;

  slbs_pkg::kind_t kind;
  logic [31:0]     elapsed;
  logic [7:0]      done_inc;
  logic            err_due;
  logic            id_due;

  assign kind     = slbs_pkg::kind_t'(mode);
  assign elapsed  = now_ms - last_r;
  assign done_inc = done_r + 8'd1;
  assign err_due  = elapsed >= {16'd0, err_half};
  assign id_due   = elapsed >= {16'd0, id_half};

  always_comb begin
    st_nxt        = st_r;
    saved_err_nxt = saved_err_r;
    last_nxt      = last_r;
    lit_nxt       = lit_r;
    wanted_nxt    = wanted_r;
    done_nxt      = done_r;
    case (kind)
      slbs_pkg::KIND_TICK: begin
        if (st_r != slbs_pkg::ST_OFF) begin
          if (last_r == 32'd0) begin
            last_nxt = now_ms;
          end else if (st_r == slbs_pkg::ST_ERROR) begin
            if (err_due) begin
              lit_nxt  = ~lit_r;
              last_nxt = now_ms;
            end
          end else if (id_due) begin
            last_nxt = now_ms;
            if (lit_r) begin
              lit_nxt  = 1'b0;
              done_nxt = done_inc;
              if (done_inc >= wanted_r) begin
                // sequence over: restore saved mode
                wanted_nxt = 8'd0;
                done_nxt   = 8'd0;
                if (saved_err_r) begin
                  st_nxt   = slbs_pkg::ST_ERROR;
                  last_nxt = 32'd0;
                  lit_nxt  = 1'b1;
                end else begin
                  st_nxt = slbs_pkg::ST_OFF;
                end
              end
            end else begin
              lit_nxt = 1'b1;
            end
          end
        end
      end
      slbs_pkg::KIND_ERROR: begin
        if (st_r == slbs_pkg::ST_IDENT) begin
          saved_err_nxt = 1'b1;
        end else begin
          st_nxt   = slbs_pkg::ST_ERROR;
          last_nxt = 32'd0;
          lit_nxt  = 1'b1;
        end
      end
      slbs_pkg::KIND_CLEAR: begin
        if (st_r == slbs_pkg::ST_IDENT) begin
          saved_err_nxt = 1'b0;
        end else begin
          st_nxt  = slbs_pkg::ST_OFF;
          lit_nxt = 1'b0;
        end
      end
      slbs_pkg::KIND_IDENTIFY: begin
        if (blink_count != 8'd0) begin
          if (st_r != slbs_pkg::ST_IDENT) begin
            saved_err_nxt = (st_r == slbs_pkg::ST_ERROR);
          end
          st_nxt     = slbs_pkg::ST_IDENT;
          wanted_nxt = blink_count;
          done_nxt   = 8'd0;
          last_nxt   = 32'd0;
          lit_nxt    = 1'b1;
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= slbs_pkg::ST_OFF;
      saved_err_r <= 1'b0;
      last_r      <= 32'd0;
      lit_r       <= 1'b0;
      wanted_r    <= 8'd0;
      done_r      <= 8'd0;
    end else if (fire) begin
      st_r        <= st_nxt;
      saved_err_r <= saved_err_nxt;
      last_r      <= last_nxt;
      lit_r       <= lit_nxt;
      wanted_r    <= wanted_nxt;
      done_r      <= done_nxt;
    end
  end

  assign result.led_lit           = lit_nxt;
  assign result.led_mode          = slbs_pkg::led_mode_code(st_nxt);
  assign result.identify_finished = (st_nxt != slbs_pkg::ST_IDENT);

endmodule

// ===== rtl/status_led_blink_sequencer.sv =====
// ----------------------------------------------------------------------------
// status_led_blink_sequencer
// Status LED controller with off, error-blink and identify-blink modes.
// ----------------------------------------------------------------------------
// Each request beat (tick, error, clear or identify) yields exactly one status
// beat with the LED state after that request; one beat per clock while the
// status side accepts beats. A beat lands in an input register, the mode state
// updates through the next-state logic, and the status goes to an output
// register. The input side stays ready while a status beat waits if the input
// register can drain. Half-periods are APB registers (error at 0x0, identify at
// 0x4); the user must write them only while no request is in flight (unchecked).
module status_led_blink_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  slbs_in_if.sink                      in_beat,
  slbs_out_if.source                   out_beat,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [slbs_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [slbs_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [slbs_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  logic [15:0] err_half;
  logic [15:0] id_half;

  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_mode_r;
  logic [31:0] s1_now_r;
  logic [7:0]  s1_count_r;

  logic              out_valid_r, out_valid_nxt;
  slbs_pkg::result_t out_res_r;
  slbs_pkg::result_t core_res;

  logic fire;
  logic in_take;

  slbs_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .err_half    (err_half),
    .id_half     (id_half)
  );

  assign fire    = s1_valid_r & (~out_valid_r | out_beat.ready);
  assign in_take = in_beat.valid & in_beat.ready;

  assign in_beat.ready = ~s1_valid_r | fire;

  assign s1_valid_nxt  = in_take | (s1_valid_r & ~fire);
  assign out_valid_nxt = fire | (out_valid_r & ~out_beat.ready);

  slbs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .mode        (s1_mode_r),
    .now_ms      (s1_now_r),
    .blink_count (s1_count_r),
    .err_half    (err_half),
    .id_half     (id_half),
    .result      (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= in_beat.mode;
      s1_now_r   <= in_beat.now_ms;
      s1_count_r <= in_beat.blink_count;
    end
    if (fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_beat.valid             = out_valid_r;
  assign out_beat.led_lit           = out_res_r.led_lit;
  assign out_beat.led_mode          = out_res_r.led_mode;
  assign out_beat.identify_finished = out_res_r.identify_finished;

endmodule
